// ----- rtl/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding window maximum: shared definitions
// Default sizes, register layout and the control word sent to every cell.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int MAX_WINDOW_DEF   = 64;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

  // Control word broadcast along the cell chain
  typedef struct packed {
    logic step;   // take in a new item
    logic purge;  // shift only: drop the front candidate, no new item
    logic shift;  // front candidate leaves; every cell takes from its upper neighbor
    logic first;  // new sequence: discard every candidate
  } ctrl_t;

endpackage

// ----- rtl/swm_cell.sv -----
// ----------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// Holds one candidate (value and age) of the monotonic list and hands it
// down to its lower neighbor when the front of the list moves.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int AGE_W        = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_t                          ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic        [AGE_W-1:0]        window,
  input  logic                           head,
  input  logic                           left_keep,
  input  logic                           up_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] up_value,
  input  logic        [AGE_W-1:0]        up_age,
  input  logic                           up_keep,
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic        [AGE_W-1:0]        age,
  output logic                           keep
);

  logic                           src_keep;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic        [AGE_W-1:0]        src_age;
  logic                           prev_ok;
  logic        [AGE_W-1:0]        age_inc;

  // Survive this item: still inside the window and larger than the new sample
  assign age_inc = age + AGE_W'(1);
  assign keep    = valid && !ctrl.first && (value > sample) && (age_inc < window);

  assign src_keep  = ctrl.shift ? up_keep  : keep;
  assign src_value = ctrl.shift ? up_value : value;
  assign src_age   = ctrl.shift ? up_age   : age;
  // The new sample lands right behind the last surviving candidate
  assign prev_ok   = head | (ctrl.shift ? keep : left_keep);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.step) begin
      if (src_keep) begin
        valid <= 1'b1;
        value <= src_value;
        age   <= src_age + AGE_W'(1);
      end else if (prev_ok) begin
        valid <= 1'b1;
        value <= sample;
        age   <= '0;
      end else begin
        valid <= 1'b0;
      end
    end else if (ctrl.purge) begin
      valid <= up_valid;
      value <= up_value;
      age   <= up_age;
    end
  end

endmodule

// ----- rtl/sliding_window_maximum_core.sv -----
// ----------------------------------------------------------------------------
// Sliding window maximum core
// Streaming maximum of the last window_size signed samples.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and answers
// with the maximum of the most recent window_size samples once that many
// samples of the current sequence have arrived; before that an item gives no
// result. The result is in the output register in the cycle after its item.
// The candidates live in a row of MAX_WINDOW cells that all compare against
// the new sample in the same cycle, so the rate is set by that single compare
// per cell and by the output register: in_stall rises only while a finished
// result waits on a stalled output, and after a write to window_size while
// the cells drop the candidates that fall outside the new window, one per
// cycle, until the front is inside the window. A window size of zero acts
// as a window of one sample and a size above MAX_WINDOW acts as MAX_WINDOW.
// Set first on an item to start a new sequence; the window is emptied before
// that sample enters.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic        [CFG_WIDTH-1:0]    cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           first,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] window_max
);

  // Ages run up to MAX_WINDOW - 1; one more bit pattern holds age + 1
  localparam int AGE_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (AGE_W > CFG_WIDTH) ? AGE_W : CFG_WIDTH;

  logic [CFG_WIDTH-1:0] window_size;
  logic [CMP_W-1:0]     window_ext;
  logic [AGE_W-1:0]     window;
  logic                 purging;
  logic [AGE_W-1:0]     seen;
  logic [AGE_W-1:0]     seen_base;
  logic [AGE_W-1:0]     seen_next;

  logic                 accept;
  logic                 stale_front;
  ctrl_t                ctrl;
  logic signed [SAMPLE_WIDTH-1:0] front_next;

  // Cell views; the extra top entry is an empty neighbor beyond the last cell
  logic                           cell_valid [MAX_WINDOW+1];
  logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW+1];
  logic        [AGE_W-1:0]        cell_age   [MAX_WINDOW+1];
  logic                           cell_keep  [MAX_WINDOW+1];

  // --------------------------------------------------------------------------
  // Configuration: clamp the window to 1..MAX_WINDOW
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  assign window_ext = CMP_W'(window_size);

  always_comb begin
    if (window_size == '0) begin
      window = AGE_W'(1);
    end else if (window_ext > CMP_W'(MAX_WINDOW)) begin
      window = AGE_W'(MAX_WINDOW);
    end else begin
      window = AGE_W'(window_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and chain control
  // --------------------------------------------------------------------------
  assign in_stall = purging || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // The front candidate is the only one that can age out of a steady window
  assign stale_front = cell_valid[0] && ((cell_age[0] + AGE_W'(1)) >= window);

  always_comb begin
    ctrl.step  = accept;
    ctrl.first = first;
    ctrl.purge = purging && stale_front;
    ctrl.shift = stale_front && (purging || !first);
  end

  // Hold the input off after a window change until no candidate lies outside
  always_ff @(posedge clk) begin
    if (rst) begin
      purging <= 1'b0;
    end else if (cfg_wr_en) begin
      purging <= 1'b1;
    end else if (purging && !stale_front) begin
      purging <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Candidate chain: front of the list sits in cell 0
  // --------------------------------------------------------------------------
  assign cell_valid[MAX_WINDOW] = 1'b0;
  assign cell_value[MAX_WINDOW] = '0;
  assign cell_age[MAX_WINDOW]   = '0;
  assign cell_keep[MAX_WINDOW]  = 1'b0;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    logic left_keep;
    if (j == 0) begin : g_head
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_keep = cell_keep[j-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (sample),
      .window    (window),
      .head      ((j == 0) ? 1'b1 : 1'b0),
      .left_keep (left_keep),
      .up_valid  (cell_valid[j+1]),
      .up_value  (cell_value[j+1]),
      .up_age    (cell_age[j+1]),
      .up_keep   (cell_keep[j+1]),
      .valid     (cell_valid[j]),
      .value     (cell_value[j]),
      .age       (cell_age[j]),
      .keep      (cell_keep[j])
    );
  end

  // Front of the list after this item: the surviving oldest candidate, else the sample
  always_comb begin
    if (ctrl.shift) begin
      front_next = cell_keep[1] ? cell_value[1] : sample;
    end else begin
      front_next = cell_keep[0] ? cell_value[0] : sample;
    end
  end

  // --------------------------------------------------------------------------
  // Fill count of the current sequence, saturating at the window
  // --------------------------------------------------------------------------
  assign seen_base = first ? '0 : seen;
  assign seen_next = (seen_base < window) ? (seen_base + AGE_W'(1)) : window;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: release on handshake, load when the window is full
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (seen_next == window)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (seen_next == window)) begin
      window_max <= front_next;
    end
  end

endmodule
